// ----- rtl/bbsr_pkg.sv -----
package bbsr_pkg;

    // scaled coordinates, Q.8
    localparam int CW = 26;
    // working width for stamp positions, Q.8
    localparam int QW = 28;
    // larger bounding box side, Q.8
    localparam int SW = 26;
    // divider numerator width
    localparam int NW = 40;
    localparam int QDEPTH = 2;

    typedef logic signed [CW-1:0] t_coord;

    typedef enum logic [1:0] {
        OP_DRAW     = 2'd0,
        OP_BRUSH_WR = 2'd1,
        OP_PIX_RD   = 2'd2,
        OP_CLEAR    = 2'd3
    } t_op;

    localparam logic [1:0]  CFG_SCALE    = 2'd0;
    localparam logic [1:0]  CFG_RADIUS   = 2'd1;
    localparam logic [16:0] SCALE_RESET  = 17'd65536;
    localparam logic [5:0]  RADIUS_RESET = 6'd4;

    typedef struct packed {
        t_op               op;
        t_coord [3:0]      sx;
        t_coord [3:0]      sy;
        logic [SW-1:0]     s8;
        logic [15:0]       steps;
        logic              sat;
        logic [15:0]       address;
        logic [23:0]       texel;
    } t_cmd;

endpackage

// ----- rtl/bbsr_front.sv -----
module bbsr_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_hold,
    input  logic [1:0]          i_op,
    input  logic signed [23:0]  i_x_start,
    input  logic signed [23:0]  i_y_start,
    input  logic signed [23:0]  i_x_ctrl_one,
    input  logic signed [23:0]  i_y_ctrl_one,
    input  logic signed [23:0]  i_x_ctrl_two,
    input  logic signed [23:0]  i_y_ctrl_two,
    input  logic signed [23:0]  i_x_end,
    input  logic signed [23:0]  i_y_end,
    input  logic [15:0]         i_address,
    input  logic [23:0]         i_texel,
    input  logic [16:0]         i_scale,
    input  logic                i_full,
    output logic                o_busy,
    output logic                o_push,
    output bbsr_pkg::t_cmd      o_cmd
);

    typedef enum logic [1:0] {F_IDLE, F_MUL, F_STORE, F_PUSH} t_fstate;

    t_fstate                        r_state;
    bbsr_pkg::t_cmd                 r_cmd;
    logic signed [23:0]             r_px [4];
    logic signed [23:0]             r_py [4];
    logic [3:0]                     r_cnt;
    logic signed [42:0]             r_prod;
    logic [bbsr_pkg::SW-1:0]        r_wq;

    logic signed [23:0]             minx, maxx, miny, maxy;
    logic signed [24:0]             wx, wy, mul_a;
    logic signed [17:0]             mul_b;
    logic signed [42:0]             w_prod;
    logic [bbsr_pkg::SW-1:0]        hq, s8;
    logic [17:0]                    full;

    always_comb begin
        minx = r_px[0];
        maxx = r_px[0];
        miny = r_py[0];
        maxy = r_py[0];
        for (int i = 1; i < 4; i++) begin
            if (r_px[i] < minx) minx = r_px[i];
            if (r_px[i] > maxx) maxx = r_px[i];
            if (r_py[i] < miny) miny = r_py[i];
            if (r_py[i] > maxy) maxy = r_py[i];
        end
        wx = {maxx[23], maxx} - {minx[23], minx};
        wy = {maxy[23], maxy} - {miny[23], miny};
        priority if (r_cnt < 4'd4) mul_a = {r_px[r_cnt[1:0]][23], r_px[r_cnt[1:0]]};
        else if (r_cnt < 4'd8)     mul_a = {r_py[r_cnt[1:0]][23], r_py[r_cnt[1:0]]};
        else if (r_cnt == 4'd8)    mul_a = wx;
        else                       mul_a = wy;
    end

    assign mul_b  = $signed({1'b0, i_scale});
    assign w_prod = mul_a * mul_b;
    assign hq     = r_prod[41:16];
    assign s8     = (r_wq > hq) ? r_wq : hq;
    assign full   = s8[bbsr_pkg::SW-1:8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (i_start && !o_busy) begin
                        r_cmd.op      <= bbsr_pkg::t_op'(i_op);
                        r_cmd.address <= i_address;
                        r_cmd.texel   <= i_texel;
                        r_cmd.steps   <= '0;
                        r_cmd.sat     <= 1'b0;
                        r_cmd.s8      <= '0;
                        r_px[0] <= i_x_start;    r_py[0] <= i_y_start;
                        r_px[1] <= i_x_ctrl_one; r_py[1] <= i_y_ctrl_one;
                        r_px[2] <= i_x_ctrl_two; r_py[2] <= i_y_ctrl_two;
                        r_px[3] <= i_x_end;      r_py[3] <= i_y_end;
                        r_cnt   <= '0;
                        r_state <= (bbsr_pkg::t_op'(i_op) == bbsr_pkg::OP_DRAW) ? F_MUL : F_PUSH;
                    end
                end
                F_MUL: begin
                    r_prod  <= w_prod;
                    r_state <= F_STORE;
                end
                F_STORE: begin
                    priority if (r_cnt < 4'd4) r_cmd.sx[r_cnt[1:0]] <= r_prod[41:16];
                    else if (r_cnt < 4'd8)     r_cmd.sy[r_cnt[1:0]] <= r_prod[41:16];
                    else if (r_cnt == 4'd8)    r_wq <= r_prod[41:16];
                    else begin
                        r_cmd.s8    <= s8;
                        r_cmd.steps <= (|full[17:16]) ? 16'hFFFF : full[15:0];
                        r_cmd.sat   <= |full[17:16];
                    end
                    if (r_cnt == 4'd9) begin
                        r_state <= F_PUSH;
                    end else begin
                        r_cnt   <= r_cnt + 4'd1;
                        r_state <= F_MUL;
                    end
                end
                F_PUSH: begin
                    if (!i_full) r_state <= F_IDLE;
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    assign o_busy = (r_state != F_IDLE) || i_hold;
    assign o_push = (r_state == F_PUSH) && !i_full;
    assign o_cmd  = r_cmd;

endmodule

// ----- rtl/bbsr_fifo.sv -----
module bbsr_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bbsr_pkg::t_cmd  i_data,
    input  logic            i_pop,
    output bbsr_pkg::t_cmd  o_data,
    output logic            o_empty,
    output logic            o_full
);

    localparam int QPW = $clog2(bbsr_pkg::QDEPTH);

    bbsr_pkg::t_cmd r_mem [bbsr_pkg::QDEPTH];
    logic [QPW-1:0] r_wp, r_rp;
    logic [QPW:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_mem[r_wp] <= i_data;
                r_wp        <= r_wp + 1'b1;
            end
            if (i_pop) r_rp <= r_rp + 1'b1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_data  = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (QPW+1)'(bbsr_pkg::QDEPTH));

endmodule

// ----- rtl/bbsr_div.sv -----
module bbsr_div (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [bbsr_pkg::NW-1:0] i_num,
    input  logic [bbsr_pkg::SW-1:0] i_den,
    output logic                    o_done,
    output logic [bbsr_pkg::NW-1:0] o_quo,
    output logic [bbsr_pkg::SW-1:0] o_rem
);

    localparam int CNW = $clog2(bbsr_pkg::NW);

    logic                    r_busy, r_done;
    logic [CNW-1:0]          r_cnt;
    logic [bbsr_pkg::NW-1:0] r_num, r_quo;
    logic [bbsr_pkg::SW-1:0] r_rem, r_den;
    logic [bbsr_pkg::SW:0]   trial, diff;
    logic                    ge;

    // one restoring step per cycle, msb first
    assign trial = {r_rem, r_num[bbsr_pkg::NW-1]};
    assign ge    = trial >= {1'b0, r_den};
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_quo  <= '0;
            end else if (r_busy) begin
                r_rem <= ge ? diff[bbsr_pkg::SW-1:0] : trial[bbsr_pkg::SW-1:0];
                r_quo <= {r_quo[bbsr_pkg::NW-2:0], ge};
                r_num <= {r_num[bbsr_pkg::NW-2:0], 1'b0};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNW'(bbsr_pkg::NW-1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

// ----- rtl/bbsr_back.sv -----
module bbsr_back #(
    parameter int IMAGE_WIDTH  = 256,
    parameter int IMAGE_HEIGHT = 256,
    parameter int BRUSH_SIZE   = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  bbsr_pkg::t_cmd          i_cmd,
    input  logic                    i_empty,
    output logic                    o_pop,
    input  logic [5:0]              i_radius,
    output logic                    o_init,
    output logic                    o_div_start,
    output logic [bbsr_pkg::NW-1:0] o_div_num,
    output logic [bbsr_pkg::SW-1:0] o_div_den,
    input  logic                    i_div_done,
    input  logic [bbsr_pkg::NW-1:0] i_div_quo,
    input  logic [bbsr_pkg::SW-1:0] i_div_rem,
    output logic                    o_valid,
    output logic [23:0]             o_pixel_value,
    output logic [15:0]             o_steps_drawn,
    output logic                    o_status
);

    localparam int FB_DEPTH = IMAGE_WIDTH * IMAGE_HEIGHT;
    localparam int FAW      = $clog2(FB_DEPTH);
    localparam int BR_DEPTH = BRUSH_SIZE * BRUSH_SIZE;
    localparam int BAW      = $clog2(BR_DEPTH);
    localparam int BQW      = $clog2(BRUSH_SIZE);
    localparam int HALF     = BRUSH_SIZE / 2;
    localparam int XW       = $clog2(IMAGE_WIDTH);
    localparam int YW       = $clog2(IMAGE_HEIGHT);
    localparam int QW       = bbsr_pkg::QW;
    localparam int CW       = bbsr_pkg::CW;
    localparam logic signed [QW-1:0] ROW_TOP = QW'((IMAGE_HEIGHT - 1) * 256);
    localparam logic signed [QW-1:0] Q8_ONE  = QW'(256);
    localparam logic signed [QW-1:0] Q8_HALF = QW'(128);

    typedef enum logic [3:0] {
        B_CLEAR, B_IDLE, B_RDPIX, B_DIVH, B_DIVT, B_MUL, B_ADD, B_PIXRD, B_PIXWR
    } t_bstate;

    function automatic logic [23:0] max_rgb(input logic [23:0] a, input logic [23:0] b);
        logic [23:0] r;
        for (int s = 0; s < 3; s++) begin
            r[s*8 +: 8] = (a[s*8 +: 8] > b[s*8 +: 8]) ? a[s*8 +: 8] : b[s*8 +: 8];
        end
        return r;
    endfunction

    t_bstate                r_state;
    logic                   r_init;
    logic [FAW-1:0]         r_clr_addr;
    bbsr_pkg::t_cmd         r_cmd;
    logic                   r_rd_ok;
    logic [15:0]            r_k;
    logic [BQW-1:0]         r_qh;
    logic [5:0]             r_rh;
    logic [15:0]            r_t;
    bbsr_pkg::t_coord       r_w [4];
    logic [2:0]             r_li;
    logic                   r_axis;
    logic signed [43:0]     r_prod;
    logic signed [QW-1:0]   r_vcol, r_vrow, r_vrow0;
    logic [6:0]             r_cx, r_cy;
    logic [BQW-1:0]         r_bqc, r_bqr;
    logic [6:0]             r_brc, r_brr;
    logic [FAW-1:0]         r_widx;
    logic                   r_div_start;
    logic                   r_valid, r_status;
    logic [23:0]            r_pix;
    logic [15:0]            r_steps;
    logic [23:0]            r_fb [FB_DEPTH];
    logic [23:0]            r_br [BR_DEPTH];
    logic [23:0]            r_fb_rd, r_br_rd;

    logic [5:0]             rad;
    logic [6:0]             two_r_m1;
    logic signed [QW-1:0]   rad256;
    logic [1:0]             lj;
    logic signed [CW:0]     ldiff;
    logic signed [43:0]     w_mul;
    logic signed [QW-1:0]   lerp_sum;
    logic signed [QW-1:0]   vcp, vrp;
    logic [XW-1:0]          dc;
    logic [YW-1:0]          dr;
    logic [31:0]            f32, b32, addr32;
    logic [FAW-1:0]         fidx;
    logic [BAW-1:0]         bidx;
    logic [6:0]             nrc, nrr;
    logic [BQW-1:0]         nqc, nqr;
    logic                   fb_we, br_we;
    logic [FAW-1:0]         fb_wa, fb_ra;
    logic [23:0]            fb_wd;
    logic                   last_y, last_x;

    assign rad      = (i_radius == 6'd0) ? 6'd1 : i_radius;
    assign two_r_m1 = {rad, 1'b0} - 7'd1;
    assign rad256   = $signed({{(QW-14){1'b0}}, rad, 8'b0});
    assign last_y   = (r_cy == two_r_m1);
    assign last_x   = (r_cx == two_r_m1);

    // in-place de casteljau: a,b,c then d,e then the point
    always_comb begin
        unique case (r_li)
            3'd1, 3'd4: lj = 2'd1;
            3'd2:       lj = 2'd2;
            default:    lj = 2'd0;
        endcase
    end

    assign ldiff    = {r_w[lj + 2'd1][CW-1], r_w[lj + 2'd1]} - {r_w[lj][CW-1], r_w[lj]};
    assign w_mul    = ldiff * $signed({1'b0, r_t});
    assign lerp_sum = {{(QW-CW){r_w[lj][CW-1]}}, r_w[lj]} + r_prod[43:16];

    // round half away from zero, negatives clamp to zero anyway
    assign vcp = r_vcol + Q8_HALF;
    assign vrp = r_vrow + Q8_HALF;

    always_comb begin
        if (r_vcol < 0)
            dc = '0;
        else if (32'(vcp[QW-1:8]) > 32'(IMAGE_WIDTH - 1))
            dc = XW'(IMAGE_WIDTH - 1);
        else
            dc = vcp[XW+7:8];
        if (r_vrow < 0)
            dr = '0;
        else if (32'(vrp[QW-1:8]) > 32'(IMAGE_HEIGHT - 1))
            dr = YW'(IMAGE_HEIGHT - 1);
        else
            dr = vrp[YW+7:8];
    end

    assign f32    = 32'(dr) * 32'(IMAGE_WIDTH) + 32'(dc);
    assign fidx   = f32[FAW-1:0];
    assign b32    = 32'(r_bqr) * 32'(BRUSH_SIZE) + 32'(r_bqc);
    assign bidx   = b32[BAW-1:0];
    assign addr32 = 32'(i_cmd.address);

    // brush index floor(half*j/r) stepped by quotient and remainder of half/r
    always_comb begin
        nrc = r_brc + {1'b0, r_rh};
        nqc = r_bqc + r_qh;
        if (nrc >= {1'b0, rad}) begin
            nrc = nrc - {1'b0, rad};
            nqc = nqc + 1'b1;
        end
        nrr = r_brr + {1'b0, r_rh};
        nqr = r_bqr + r_qh;
        if (nrr >= {1'b0, rad}) begin
            nrr = nrr - {1'b0, rad};
            nqr = nqr + 1'b1;
        end
    end

    assign o_pop = (r_state == B_IDLE) && !i_empty;

    assign fb_we = (r_state == B_CLEAR) || (r_state == B_PIXWR);
    assign fb_wa = (r_state == B_CLEAR) ? r_clr_addr : r_widx;
    assign fb_wd = (r_state == B_CLEAR) ? 24'd0 : max_rgb(r_fb_rd, r_br_rd);
    assign fb_ra = (r_state == B_PIXRD) ? fidx : addr32[FAW-1:0];
    assign br_we = o_pop && (i_cmd.op == bbsr_pkg::OP_BRUSH_WR)
                   && (addr32 < 32'(BR_DEPTH));

    always_ff @(posedge i_clk) begin
        if (fb_we) r_fb[fb_wa] <= fb_wd;
        r_fb_rd <= r_fb[fb_ra];
    end

    always_ff @(posedge i_clk) begin
        if (br_we) r_br[addr32[BAW-1:0]] <= i_cmd.texel;
        r_br_rd <= r_br[bidx];
    end

    always_comb begin
        if (r_state == B_DIVH) begin
            o_div_num = bbsr_pkg::NW'(HALF);
            o_div_den = bbsr_pkg::SW'(rad);
        end else begin
            o_div_num = {r_k, 24'd0};
            o_div_den = r_cmd.s8;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_init      <= 1'b1;
            r_clr_addr  <= '0;
            r_valid     <= 1'b0;
            r_div_start <= 1'b0;
        end else begin
            r_valid     <= 1'b0;
            r_div_start <= 1'b0;
            unique case (r_state)
                B_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == FAW'(FB_DEPTH - 1)) begin
                        r_state <= B_IDLE;
                        r_init  <= 1'b0;
                        if (!r_init) begin
                            r_valid  <= 1'b1;
                            r_pix    <= '0;
                            r_steps  <= '0;
                            r_status <= 1'b0;
                        end
                    end
                end
                B_IDLE: begin
                    if (!i_empty) begin
                        r_cmd <= i_cmd;
                        unique case (i_cmd.op)
                            bbsr_pkg::OP_DRAW: begin
                                if (i_cmd.steps == 16'd0) begin
                                    r_valid  <= 1'b1;
                                    r_pix    <= '0;
                                    r_steps  <= '0;
                                    r_status <= 1'b0;
                                end else begin
                                    r_div_start <= 1'b1;
                                    r_state     <= B_DIVH;
                                end
                            end
                            bbsr_pkg::OP_BRUSH_WR: begin
                                r_valid  <= 1'b1;
                                r_pix    <= '0;
                                r_steps  <= '0;
                                r_status <= 1'b0;
                            end
                            bbsr_pkg::OP_PIX_RD: begin
                                r_rd_ok <= addr32 < 32'(FB_DEPTH);
                                r_state <= B_RDPIX;
                            end
                            bbsr_pkg::OP_CLEAR: begin
                                r_clr_addr <= '0;
                                r_state    <= B_CLEAR;
                            end
                            default: r_state <= B_IDLE;
                        endcase
                    end
                end
                B_RDPIX: begin
                    r_valid  <= 1'b1;
                    r_pix    <= r_rd_ok ? r_fb_rd : 24'd0;
                    r_steps  <= '0;
                    r_status <= 1'b0;
                    r_state  <= B_IDLE;
                end
                B_DIVH: begin
                    if (i_div_done) begin
                        r_qh        <= i_div_quo[BQW-1:0];
                        r_rh        <= i_div_rem[5:0];
                        r_k         <= '0;
                        r_div_start <= 1'b1;
                        r_state     <= B_DIVT;
                    end
                end
                B_DIVT: begin
                    if (i_div_done) begin
                        r_t <= i_div_quo[15:0];
                        for (int i = 0; i < 4; i++) r_w[i] <= r_cmd.sx[i];
                        r_li    <= '0;
                        r_axis  <= 1'b0;
                        r_state <= B_MUL;
                    end
                end
                B_MUL: begin
                    r_prod  <= w_mul;
                    r_state <= B_ADD;
                end
                B_ADD: begin
                    if (r_li == 3'd5) begin
                        if (!r_axis) begin
                            r_vcol <= lerp_sum - rad256;
                            for (int i = 0; i < 4; i++) r_w[i] <= r_cmd.sy[i];
                            r_axis  <= 1'b1;
                            r_li    <= '0;
                            r_state <= B_MUL;
                        end else begin
                            // flip the row
                            r_vrow  <= ROW_TOP - lerp_sum - rad256;
                            r_vrow0 <= ROW_TOP - lerp_sum - rad256;
                            r_cx    <= '0;
                            r_cy    <= '0;
                            r_bqc   <= '0;
                            r_brc   <= '0;
                            r_bqr   <= '0;
                            r_brr   <= '0;
                            r_state <= B_PIXRD;
                        end
                    end else begin
                        r_w[lj] <= lerp_sum[CW-1:0];
                        r_li    <= r_li + 3'd1;
                        r_state <= B_MUL;
                    end
                end
                B_PIXRD: begin
                    r_widx  <= fidx;
                    r_state <= B_PIXWR;
                end
                B_PIXWR: begin
                    if (last_y) begin
                        r_cy   <= '0;
                        r_vrow <= r_vrow0;
                        r_bqr  <= '0;
                        r_brr  <= '0;
                        if (last_x) begin
                            if ({1'b0, r_k} + 17'd1 == {1'b0, r_cmd.steps}) begin
                                r_valid  <= 1'b1;
                                r_pix    <= '0;
                                r_steps  <= r_cmd.steps;
                                r_status <= r_cmd.sat;
                                r_state  <= B_IDLE;
                            end else begin
                                r_k         <= r_k + 16'd1;
                                r_div_start <= 1'b1;
                                r_state     <= B_DIVT;
                            end
                        end else begin
                            r_cx    <= r_cx + 7'd1;
                            r_vcol  <= r_vcol + Q8_ONE;
                            r_bqc   <= nqc;
                            r_brc   <= nrc;
                            r_state <= B_PIXRD;
                        end
                    end else begin
                        r_cy    <= r_cy + 7'd1;
                        r_vrow  <= r_vrow + Q8_ONE;
                        r_bqr   <= nqr;
                        r_brr   <= nrr;
                        r_state <= B_PIXRD;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_init        = r_init;
    assign o_div_start   = r_div_start;
    assign o_valid       = r_valid;
    assign o_pixel_value = r_pix;
    assign o_steps_drawn = r_steps;
    assign o_status      = r_status;

    a_result_at_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_state == B_IDLE)
        else $error("result strobe while back end still working");

    a_div_start_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_start |-> (r_state == B_DIVH || r_state == B_DIVT))
        else $error("divider started outside a divide state");

    a_write_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == B_PIXWR |=> r_state == B_PIXRD || r_state == B_IDLE
                               || r_state == B_DIVT)
        else $error("stamp write not followed by read, step or finish");

    a_no_result_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_init |-> !r_valid)
        else $error("result during power-up clear");

endmodule

// ----- rtl/bezier_brush_stroke_rasterizer.sv -----
// cubic bezier stroke rasterizer with square brush stamping
//
// command channel: an item is taken when start is high and busy is low.
// operation selects draw segment, write brush texel, read pixel or clear.
// each item gives exactly one result, shown for one cycle with
// o_result_valid; the receiver cannot stall, so results are never held.
// configuration: i_cfg_valid/o_cfg_ready with i_cfg_index (0 scale,
// 1 brush radius) and i_cfg_data; o_cfg_ready is always high.
// a front end latches and scales the control points (one shared 25x18
// multiplier) and queues the request in a two-entry queue.
// the back end runs it; a clear writes one framebuffer word a cycle.
// a draw has a setup divide for the brush step, then per step a serial
// divide for t, 12 lerps on one multiplier and one read-modify-write
// per brush texel over the (2R)^2 stamp.
// after reset the framebuffer is swept to zero; busy stays high meanwhile,
// configuration writes are still taken.
module bezier_brush_stroke_rasterizer #(
    parameter int IMAGE_WIDTH  = 256,
    parameter int IMAGE_HEIGHT = 256,
    parameter int BRUSH_SIZE   = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          i_operation,
    input  logic signed [23:0]  i_x_start,
    input  logic signed [23:0]  i_y_start,
    input  logic signed [23:0]  i_x_ctrl_one,
    input  logic signed [23:0]  i_y_ctrl_one,
    input  logic signed [23:0]  i_x_ctrl_two,
    input  logic signed [23:0]  i_y_ctrl_two,
    input  logic signed [23:0]  i_x_end,
    input  logic signed [23:0]  i_y_end,
    input  logic [15:0]         i_address,
    input  logic [23:0]         i_texel,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [16:0]         i_cfg_data,
    output logic                o_result_valid,
    output logic [23:0]         o_pixel_value,
    output logic [15:0]         o_steps_drawn,
    output logic                o_status
);

    logic [16:0]                r_scale;
    logic [5:0]                 r_radius;
    logic                       init, push, pop, empty, full;
    bbsr_pkg::t_cmd             front_cmd, queue_cmd;
    logic                       div_start, div_done;
    logic [bbsr_pkg::NW-1:0]    div_num, div_quo;
    logic [bbsr_pkg::SW-1:0]    div_den, div_rem;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale  <= bbsr_pkg::SCALE_RESET;
            r_radius <= bbsr_pkg::RADIUS_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == bbsr_pkg::CFG_SCALE)  r_scale  <= i_cfg_data;
            if (i_cfg_index == bbsr_pkg::CFG_RADIUS) r_radius <= i_cfg_data[5:0];
        end
    end

    bbsr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_hold       (init),
        .i_op         (i_operation),
        .i_x_start    (i_x_start),
        .i_y_start    (i_y_start),
        .i_x_ctrl_one (i_x_ctrl_one),
        .i_y_ctrl_one (i_y_ctrl_one),
        .i_x_ctrl_two (i_x_ctrl_two),
        .i_y_ctrl_two (i_y_ctrl_two),
        .i_x_end      (i_x_end),
        .i_y_end      (i_y_end),
        .i_address    (i_address),
        .i_texel      (i_texel),
        .i_scale      (r_scale),
        .i_full       (full),
        .o_busy       (busy),
        .o_push       (push),
        .o_cmd        (front_cmd)
    );

    bbsr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .i_pop   (pop),
        .o_data  (queue_cmd),
        .o_empty (empty),
        .o_full  (full)
    );

    bbsr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    bbsr_back #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT),
        .BRUSH_SIZE   (BRUSH_SIZE)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (queue_cmd),
        .i_empty       (empty),
        .o_pop         (pop),
        .i_radius      (r_radius),
        .o_init        (init),
        .o_div_start   (div_start),
        .o_div_num     (div_num),
        .o_div_den     (div_den),
        .i_div_done    (div_done),
        .i_div_quo     (div_quo),
        .i_div_rem     (div_rem),
        .o_valid       (o_result_valid),
        .o_pixel_value (o_pixel_value),
        .o_steps_drawn (o_steps_drawn),
        .o_status      (o_status)
    );

endmodule
